// ----- design/skl_pkg.sv -----
package skl_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 32;
  localparam int IN_KEY_W = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef logic [KEY_BITS-1:0] key_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic ins;
    logic del;
    key_t key;
    logic key_signed;
  } skl_ctrl_t;

  // Prefix flags passed from each cell to the next one up.
  typedef struct packed {
    logic ins_hit;
    logic del_hit;
  } skl_link_t;

  // Map a key onto an unsigned value that sorts in the configured order.
  function automatic key_t order_key(input key_t k, input logic key_signed);
    key_t v;
    v = k;
    if (key_signed) begin
      v[KEY_BITS-1] = ~k[KEY_BITS-1];
    end
    return v;
  endfunction

endpackage

// ----- design/skl_cell.sv -----
module skl_cell (
  input  logic              clk,
  input  skl_pkg::skl_ctrl_t ctrl,
  input  logic              occupied,
  input  skl_pkg::key_t     left_key,
  input  skl_pkg::key_t     right_key,
  input  skl_pkg::skl_link_t link_in,
  output skl_pkg::skl_link_t link_out,
  output skl_pkg::key_t     key_out
);
  import skl_pkg::*;

  key_t key_r;
  key_t key_nxt;
  logic ge;
  logic match;

  // An empty slot counts as "not smaller", so the first empty slot is the tail.
  assign ge    = ~occupied |
                 (order_key(key_r, ctrl.key_signed) >= order_key(ctrl.key, ctrl.key_signed));
  assign match = occupied & (key_r == ctrl.key);

  assign link_out.ins_hit = link_in.ins_hit | ge;
  assign link_out.del_hit = link_in.del_hit | match;
  assign key_out          = key_r;

  always_comb begin
    key_nxt = key_r;
    if (ctrl.ins) begin
      if (link_in.ins_hit) begin
        key_nxt = left_key;
      end else if (ge) begin
        key_nxt = ctrl.key;
      end
    end
    // Close the gap at and above the first match.
    if (ctrl.del && (link_in.del_hit || match)) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

// ----- design/sorted_key_list.sv -----
// Sorted key list: holds up to CAPACITY keys in ascending order (unsigned, or two's
// complement when key_signed is set) in a row of cells, one key per cell. For each command
// (insert, erase one match, search) every cell compares its key with the command key at
// once, a prefix flag ripples up the row, and inserts shift the upper keys up one cell
// while erases shift them down. One item is accepted per cycle while in_stall is low;
// its status and the resulting count appear in the output register on the next cycle
// and are held while out_stall is high. Insert on a full list returns "full", erase or
// search on an empty list returns "empty", and an unknown command returns "not found".
module sorted_key_list (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_cmd,
  input  logic [skl_pkg::IN_KEY_W-1:0] in_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [skl_pkg::CNT_W-1:0]  out_count
);
  import skl_pkg::*;

  logic                 key_signed_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [CNT_W-1:0]     out_count_r;

  logic                 accept;
  cmd_t                 cmd;
  logic                 full;
  logic                 empty;
  logic                 any_match;
  status_t              status;
  skl_ctrl_t            ctrl;
  logic [CAPACITY-1:0]  occupied;
  skl_link_t            link [CAPACITY+1];
  key_t                 keys [CAPACITY];

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign cmd      = cmd_t'(in_cmd);
  assign full     = (count_r >= CNT_W'(CAPACITY));
  assign empty    = (count_r == '0);

  assign ctrl.key        = in_key[KEY_BITS-1:0];
  assign ctrl.key_signed = key_signed_r;
  assign ctrl.ins        = accept & (cmd == CMD_INSERT) & ~full;
  assign ctrl.del        = accept & (cmd == CMD_ERASE) & ~empty & any_match;

  assign link[0]   = '0;
  assign any_match = link[CAPACITY].del_hit;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occupied[i] = (CNT_W'(i) < count_r);
    skl_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (occupied[i]),
      .left_key ((i == 0) ? ctrl.key : keys[(i == 0) ? 0 : i - 1]),
      .right_key(keys[(i == CAPACITY - 1) ? i : i + 1]),
      .link_in  (link[i]),
      .link_out (link[i+1]),
      .key_out  (keys[i])
    );
  end

  always_comb begin
    status    = ST_NOT_FOUND;
    count_nxt = count_r;
    case (cmd)
      CMD_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          status    = ST_OK;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      CMD_ERASE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (any_match) begin
          status    = ST_OK;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      CMD_SEARCH: begin
        if (empty) begin
          status = ST_EMPTY;
        end else if (any_match) begin
          status = ST_OK;
        end
      end
      default: begin
        status = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_signed_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_signed_r <= cfg_wdata;
      end
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status;
      out_count_r  <= count_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("held count exceeds capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && (out_count_r == count_r))
    else $error("accepted item did not produce its result");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd == CMD_INSERT && !full) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !accept)
    else $error("item accepted while result is stalled");

endmodule

// ----- dv/tb_sorted_key_list.sv -----
module tb_sorted_key_list;
  timeunit 1ns;
  timeprecision 1ps;

  import skl_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic [1:0]          cmd;
    logic [IN_KEY_W-1:0] key;
  } list_op_t;

  typedef struct {
    status_t          status;
    logic [CNT_W-1:0] count;
  } list_reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic                cfg_wdata = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          in_cmd = CMD_SEARCH;
  logic [IN_KEY_W-1:0] in_key = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_status;
  logic [CNT_W-1:0]    out_count;

  list_op_t    ops_to_send[$];
  list_reply_t replies_due[$];
  key_t        shadow_keys[$];
  logic        shadow_signed = 1'b0;
  key_t        key_pool[8];

  logic in_took = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_go = 1'b0;
  bit   calm = 1'b0;
  int   err_cnt = 0;
  int   idle_cycles = 0;

  sorted_key_list u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_cmd     (in_cmd),
    .in_key     (in_key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_count  (out_count)
  );

  always #5 clk = ~clk;

  // Flip the sign bit in signed mode so an unsigned compare gives the right order.
  function automatic key_t sort_value(input key_t k);
    return {k[KEY_BITS-1] ^ shadow_signed, k[KEY_BITS-2:0]};
  endfunction

  function automatic list_reply_t predict_list_op(input logic [1:0] cmd, input key_t k);
    list_reply_t r;
    int          hit;
    int          at;
    r.status = ST_NOT_FOUND;
    hit = -1;
    for (int i = 0; i < shadow_keys.size(); i++) begin
      if (hit < 0 && shadow_keys[i] == k) begin
        hit = i;
      end
    end
    case (cmd)
      CMD_INSERT: begin
        if (shadow_keys.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          at = shadow_keys.size();
          for (int i = shadow_keys.size() - 1; i >= 0; i--) begin
            if (sort_value(shadow_keys[i]) >= sort_value(k)) begin
              at = i;
            end
          end
          shadow_keys.insert(at, k);
          r.status = ST_OK;
        end
      end
      CMD_ERASE: begin
        if (shadow_keys.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (hit >= 0) begin
          shadow_keys.delete(hit);
          r.status = ST_OK;
        end
      end
      CMD_SEARCH: begin
        if (shadow_keys.size() == 0) begin
          r.status = ST_EMPTY;
        end else if (hit >= 0) begin
          r.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    r.count = CNT_W'(shadow_keys.size());
    return r;
  endfunction

  // Sender: hold an item until it is taken, then advance or idle for a burst.
  always @(negedge clk) begin
    list_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (ops_to_send.size() > 0) begin
        op = ops_to_send.pop_front();
        in_valid <= 1'b1;
        in_cmd <= op.cmd;
        in_key <= op.key;
        if (!calm && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go) begin
      hold_go = 1'b0;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check the result first: an item taken at this edge cannot have produced it.
  always @(posedge clk) begin
    list_reply_t want;
    if (rst_n) begin
      in_took <= in_valid && !in_stall;
      if (cfg_we) begin
        shadow_signed = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected result status=%0d count=%0d", $time, out_status,
                   out_count);
          err_cnt++;
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch expected %0d actual %0d", $time, want.status,
                     out_status);
            err_cnt++;
          end
          if (out_count !== want.count) begin
            $display("%0t: count mismatch expected %0d actual %0d", $time, want.count,
                     out_count);
            err_cnt++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        replies_due.push_back(predict_list_op(in_cmd, in_key[KEY_BITS-1:0]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_op(input logic [1:0] cmd, input logic [IN_KEY_W-1:0] key);
    list_op_t op;
    op.cmd = cmd;
    op.key = key;
    ops_to_send.push_back(op);
  endtask

  // Mostly keys from a small pool so inserts collide and erases hit.
  task automatic queue_random(input int n, input int ins_pct);
    int r;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      queue_op(r < 2 ? CMD_UNUSED :
               r < 2 + ins_pct ? CMD_INSERT :
               r < 2 + ins_pct + (98 - ins_pct) / 2 ? CMD_ERASE : CMD_SEARCH,
               $urandom_range(0, 4) == 0 ? $urandom : key_pool[$urandom_range(0, 7)]);
    end
  endtask

  task automatic wait_drained();
    while (!(ops_to_send.size() == 0 && !in_valid && replies_due.size() == 0)) begin
      @(posedge clk);
    end
  endtask

  task automatic write_key_mode(input logic mode);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_key_mode(1'b0);
    queue_op(CMD_SEARCH, 32'h0);
    queue_op(CMD_ERASE, 32'h0);
    queue_op(CMD_UNUSED, 32'hFFFF_FFFF);
    queue_op(CMD_INSERT, 32'h0);
    queue_op(CMD_INSERT, 32'hFFFF_FFFF);
    queue_op(CMD_INSERT, 32'h8000_0000);
    queue_op(CMD_INSERT, 32'h7FFF_FFFF);
    queue_op(CMD_INSERT, 32'h1);
    queue_op(CMD_INSERT, 32'h5);
    queue_op(CMD_INSERT, 32'h5);
    queue_op(CMD_INSERT, 32'h5);
    queue_op(CMD_SEARCH, 32'h5);
    queue_op(CMD_SEARCH, 32'h6);
    queue_op(CMD_ERASE, 32'h5);
    queue_op(CMD_ERASE, 32'h6);
    for (int i = 0; i < 9; i++) begin
      queue_op(CMD_INSERT, 32'h100 + 3 * i);
    end
    queue_op(CMD_INSERT, 32'h9);

    for (int p = 0; p < 8; p++) begin
      wait_drained();
      repeat (3) @(posedge clk);
      write_key_mode(p[0] ? 1'b0 : 1'b1);
      key_pool[0] = 32'h0;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;
      for (int i = 4; i < 8; i++) begin
        key_pool[i] = $urandom;
      end
      if (p == 7) begin
        calm = 1'b1;
      end
      queue_random(100, 60);
      if (p == 1) begin
        @(posedge clk);
        hold_go = 1'b1;
      end
      if (p % 3 == 0) begin
        wait_drained();
      end
      queue_random(100, 25);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
